[rtl/core/mts_pkg.sv]
// shared types and codes for the multi timer scheduler
package mts_pkg;

   typedef enum logic [2:0] {
      OP_ALLOC  = 3'd0,
      OP_START  = 3'd1,
      OP_STOP   = 3'd2,
      OP_DELETE = 3'd3,
      OP_TICK   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NO_SLOT     = 2'd1,
      ST_NOT_ALLOC   = 2'd2,
      ST_STOPPED     = 2'd3
   } status_type;

   localparam int MODE_ONCE     = 0;
   localparam int MODE_RELATIVE = 1;
   localparam int MODE_AUTO_DEL = 2;

   localparam int MAX_FIRES = 15;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  timer_index;
      logic [31:0] period;
      logic [2:0]  mode_bits;
      logic [31:0] now_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  result_index;
      logic        fired;
      logic [31:0] wait_time;
      logic        last;
   } rsp_type;

endpackage

[rtl/core/mts_ram.sv]
// generic single write, single read ram with registered read data
module mts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/core/mts_rem.sv]
// iterative restoring remainder unit, one quotient bit per cycle
module mts_rem (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] remainder
);
   logic        run_ff, run_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dq_ff, dq_in;
   logic [31:0] dv_ff, dv_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      dv_in   = dv_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dq_ff[31]};
      if (go) begin
         run_in = 1'b1;
         cnt_in = 6'd0;
         rem_in = 32'd0;
         dq_in  = dividend;
         dv_in  = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, dv_ff}) begin
            rem_in = 32'(trial - {1'b0, dv_ff});
         end else begin
            rem_in = trial[31:0];
         end
         dq_in  = {dq_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dv_ff  <= dv_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

[rtl/core/multi_timer_scheduler.sv]
// multi timer scheduler top level: command decode, slot scan sequencer, timer rams
//
// usage: a command is taken at a clock edge with start high and busy low; busy
// stays high until the cycle in which the last result is shown. results appear on
// rsp_data for one cycle each with rsp_valid high and cannot be held off.
// create, start, stop, delete and unknown codes show their one result after the
// execute state, through the result register. a tick scans all TIMER_SLOTS
// slots through one shared due/age comparator: one scan per fired timer, one
// that finds nothing more due (left out once 15 have fired) and a final one for
// the wait time. each reload passes through a reload state, an absolute timer
// that is far behind also waits for the remainder unit, and reloaded timers are
// restamped one per cycle before the final scan. the next command can be taken
// at the edge that ends the result flagged last.
// csr_data sets the early fire margin; the port is always ready, and the user must
// write it only while the block is idle; the block itself does not enforce this.
// reset (synchronous, active high) frees all slots, clears the insert counter
// and the margin, and needs no clearing pass: ram contents are only read for
// running slots, which start always wrote.
module multi_timer_scheduler #(
   parameter int TIMER_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mts_pkg::req_type req_data,
   output logic             rsp_valid,
   output mts_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);
   localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CW = $clog2(TIMER_SLOTS + 1);
   localparam int ADDR_SLOTS = (TIMER_SLOTS < 16) ? TIMER_SLOTS : 16;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_SCAN, S_DECIDE, S_RELOAD, S_REM, S_STAMP
   } state_type;

   state_type        state_ff, state_in;
   mts_pkg::req_type req_ff, req_in;
   mts_pkg::rsp_type rsp_ff, rsp_in;
   logic             rspv_ff, rspv_in;
   logic             alloc_ff [TIMER_SLOTS];
   logic             alloc_in [TIMER_SLOTS];
   logic             run_ff   [TIMER_SLOTS];
   logic             run_in   [TIMER_SLOTS];
   logic [2:0]       mode_ff  [TIMER_SLOTS];
   logic [2:0]       mode_in  [TIMER_SLOTS];
   logic             done_ff  [TIMER_SLOTS];
   logic             done_in  [TIMER_SLOTS];
   logic [31:0]      ctr_ff, ctr_in;
   logic [15:0]      margin_ff, margin_in;
   logic [32:0]      limit_ff, limit_in;
   logic [CW-1:0]    scan_ff, scan_in;
   logic             pv_ff, pv_in;
   logic [IW-1:0]    pidx_ff, pidx_in;
   logic             bv_ff, bv_in;
   logic [IW-1:0]    bidx_ff, bidx_in;
   logic [31:0]      bdue_ff, bdue_in;
   logic [31:0]      bage_ff, bage_in;
   logic [3:0]       nf_ff, nf_in;
   logic [3:0]       nr_ff, nr_in;
   logic [3:0]       st_ff, st_in;
   logic [IW-1:0]    order_ff [mts_pkg::MAX_FIRES];
   logic [IW-1:0]    order_in [mts_pkg::MAX_FIRES];
   logic             final_ff, final_in;
   logic [31:0]      peff_ff, peff_in;

   logic [IW-1:0]    rd_addr;
   logic             due_we, per_we, stm_we;
   logic [IW-1:0]    due_wa, stm_wa;
   logic [31:0]      due_wd, stm_wd;
   logic [31:0]      due_q, per_q, stm_q;

   logic             rem_go, rem_done;
   logic [31:0]      rem_dividend, rem_q;

   logic [IW-1:0]    ix_slot;
   logic             ix_ok;
   logic             free_found;
   logic [IW-1:0]    free_idx;
   logic [31:0]      age;
   logic [32:0]      abs_sum;
   logic [31:0]      p_eff;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   assign ix_slot = IW'(req_ff.timer_index);
   assign ix_ok   = (32'(req_ff.timer_index) < ADDR_SLOTS) && alloc_ff[ix_slot];
   assign age     = ctr_ff - stm_q;
   assign p_eff   = (per_q == 32'd0) ? 32'd1 : per_q;
   assign abs_sum = {1'b0, bdue_ff} + {1'b0, p_eff};
   assign rem_dividend = req_ff.now_time - abs_sum[31:0];

   // lowest free slot among the addressable ones
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int k = ADDR_SLOTS - 1; k >= 0; k--) begin
         if (!alloc_ff[k]) begin
            free_found = 1'b1;
            free_idx   = IW'(k);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      rspv_in   = 1'b0;
      alloc_in  = alloc_ff;
      run_in    = run_ff;
      mode_in   = mode_ff;
      done_in   = done_ff;
      ctr_in    = ctr_ff;
      margin_in = margin_ff;
      limit_in  = limit_ff;
      scan_in   = scan_ff;
      pv_in     = 1'b0;
      pidx_in   = pidx_ff;
      bv_in     = bv_ff;
      bidx_in   = bidx_ff;
      bdue_in   = bdue_ff;
      bage_in   = bage_ff;
      nf_in     = nf_ff;
      nr_in     = nr_ff;
      st_in     = st_ff;
      order_in  = order_ff;
      final_in  = final_ff;
      peff_in   = peff_ff;
      rd_addr   = bidx_ff;
      due_we    = 1'b0;
      due_wa    = bidx_ff;
      due_wd    = req_ff.now_time + req_ff.period;
      per_we    = 1'b0;
      stm_we    = 1'b0;
      stm_wa    = ix_slot;
      stm_wd    = ctr_ff;
      rem_go    = 1'b0;

      if (csr_valid) begin
         margin_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_in         = '0;
            rsp_in.last    = 1'b1;
            rsp_in.result_index = req_ff.timer_index;
            rspv_in        = 1'b1;
            state_in       = S_IDLE;
            case (req_ff.op)
               mts_pkg::OP_ALLOC: begin
                  if (free_found) begin
                     alloc_in[free_idx] = 1'b1;
                     run_in[free_idx]   = 1'b0;
                     mode_in[free_idx]  = 3'd0;
                     rsp_in.result_index = 4'(free_idx);
                  end else begin
                     rsp_in.status       = mts_pkg::ST_NO_SLOT;
                     rsp_in.result_index = 4'd0;
                  end
               end
               mts_pkg::OP_START: begin
                  if (!ix_ok) begin
                     rsp_in.status = mts_pkg::ST_NOT_ALLOC;
                  end else begin
                     mode_in[ix_slot] = mode_ff[ix_slot] | req_ff.mode_bits;
                     run_in[ix_slot]  = 1'b1;
                     per_we = 1'b1;
                     due_we = 1'b1;
                     due_wa = ix_slot;
                     stm_we = 1'b1;
                     ctr_in = ctr_ff + 32'd1;
                  end
               end
               mts_pkg::OP_STOP: begin
                  if (!ix_ok) begin
                     rsp_in.status = mts_pkg::ST_NOT_ALLOC;
                  end else if (!run_ff[ix_slot]) begin
                     rsp_in.status = mts_pkg::ST_STOPPED;
                  end else begin
                     run_in[ix_slot] = 1'b0;
                     if (mode_ff[ix_slot][mts_pkg::MODE_AUTO_DEL]) begin
                        alloc_in[ix_slot] = 1'b0;
                        mode_in[ix_slot]  = 3'd0;
                     end
                  end
               end
               mts_pkg::OP_DELETE: begin
                  if (!ix_ok) begin
                     rsp_in.status = mts_pkg::ST_NOT_ALLOC;
                  end else begin
                     alloc_in[ix_slot] = 1'b0;
                     run_in[ix_slot]   = 1'b0;
                     mode_in[ix_slot]  = 3'd0;
                  end
               end
               mts_pkg::OP_TICK: begin
                  rspv_in  = 1'b0;
                  limit_in = {1'b0, req_ff.now_time} + {17'd0, margin_ff};
                  nf_in    = 4'd0;
                  nr_in    = 4'd0;
                  final_in = 1'b0;
                  for (int k = 0; k < TIMER_SLOTS; k++) begin
                     done_in[k] = 1'b0;
                  end
                  scan_in  = '0;
                  bv_in    = 1'b0;
                  state_in = S_SCAN;
               end
               default: begin
                  rsp_in.result_index = 4'd0;
               end
            endcase
         end
         S_SCAN: begin
            // address goes out in the cycle before the compare
            if (32'(scan_ff) < TIMER_SLOTS) begin
               rd_addr = scan_ff[IW-1:0];
               pv_in   = 1'b1;
               pidx_in = scan_ff[IW-1:0];
               scan_in = scan_ff + CW'(1);
            end else begin
               state_in = S_DECIDE;
            end
            if (pv_ff && run_ff[pidx_ff] && !done_ff[pidx_ff]) begin
               if (!bv_ff || due_q < bdue_ff || (due_q == bdue_ff && age < bage_ff)) begin
                  bv_in   = 1'b1;
                  bidx_in = pidx_ff;
                  bdue_in = due_q;
                  bage_in = age;
               end
            end
         end
         S_DECIDE: begin
            rsp_in = '0;
            if (final_ff) begin
               rsp_in.last = 1'b1;
               if (bv_ff) begin
                  rsp_in.wait_time = (bdue_ff > req_ff.now_time) ?
                                     bdue_ff - req_ff.now_time : 32'd1;
               end
               rspv_in  = 1'b1;
               state_in = S_IDLE;
            end else if (!bv_ff || {1'b0, bdue_ff} > limit_ff) begin
               st_in    = 4'd0;
               state_in = S_STAMP;
            end else begin
               rsp_in.fired        = 1'b1;
               rsp_in.result_index = 4'(bidx_ff);
               rspv_in             = 1'b1;
               done_in[bidx_ff]    = 1'b1;
               nf_in               = nf_ff + 4'd1;
               scan_in             = '0;
               bv_in               = 1'b0;
               if (mode_ff[bidx_ff][mts_pkg::MODE_AUTO_DEL]) begin
                  alloc_in[bidx_ff] = 1'b0;
                  run_in[bidx_ff]   = 1'b0;
                  mode_in[bidx_ff]  = 3'd0;
                  state_in = (nf_ff == 4'(mts_pkg::MAX_FIRES - 1)) ? S_STAMP : S_SCAN;
               end else if (mode_ff[bidx_ff][mts_pkg::MODE_ONCE]) begin
                  run_in[bidx_ff] = 1'b0;
                  state_in = (nf_ff == 4'(mts_pkg::MAX_FIRES - 1)) ? S_STAMP : S_SCAN;
               end else begin
                  // period read for the reload
                  rd_addr  = bidx_ff;
                  state_in = S_RELOAD;
               end
               st_in = 4'd0;
            end
         end
         S_RELOAD: begin
            order_in[nr_ff] = bidx_ff;
            nr_in           = nr_ff + 4'd1;
            peff_in         = p_eff;
            state_in = (nf_ff == 4'(mts_pkg::MAX_FIRES)) ? S_STAMP : S_SCAN;
            if (mode_ff[bidx_ff][mts_pkg::MODE_RELATIVE]) begin
               due_we = 1'b1;
               due_wd = req_ff.now_time + per_q;
            end else if (abs_sum > {1'b0, req_ff.now_time}) begin
               due_we = 1'b1;
               due_wd = abs_sum[31:0];
            end else begin
               rem_go   = 1'b1;
               state_in = S_REM;
            end
         end
         S_REM: begin
            if (rem_done) begin
               due_we = 1'b1;
               due_wd = req_ff.now_time - rem_q + peff_ff;
               state_in = (nf_ff == 4'(mts_pkg::MAX_FIRES)) ? S_STAMP : S_SCAN;
            end
         end
         S_STAMP: begin
            if (st_ff < nr_ff) begin
               stm_we = 1'b1;
               stm_wa = order_ff[st_ff];
               ctr_in = ctr_ff + 32'd1;
               st_in  = st_ff + 4'd1;
            end else begin
               for (int k = 0; k < TIMER_SLOTS; k++) begin
                  done_in[k] = 1'b0;
               end
               final_in = 1'b1;
               scan_in  = '0;
               bv_in    = 1'b0;
               state_in = S_SCAN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rspv_ff   <= 1'b0;
         ctr_ff    <= 32'd0;
         margin_ff <= 16'd0;
         pv_ff     <= 1'b0;
         for (int k = 0; k < TIMER_SLOTS; k++) begin
            alloc_ff[k] <= 1'b0;
            run_ff[k]   <= 1'b0;
            mode_ff[k]  <= 3'd0;
         end
      end else begin
         state_ff  <= state_in;
         rspv_ff   <= rspv_in;
         ctr_ff    <= ctr_in;
         margin_ff <= margin_in;
         pv_ff     <= pv_in;
         alloc_ff  <= alloc_in;
         run_ff    <= run_in;
         mode_ff   <= mode_in;
      end
      rsp_ff   <= rsp_in;
      req_ff   <= req_in;
      done_ff  <= done_in;
      limit_ff <= limit_in;
      scan_ff  <= scan_in;
      pidx_ff  <= pidx_in;
      bv_ff    <= bv_in;
      bidx_ff  <= bidx_in;
      bdue_ff  <= bdue_in;
      bage_ff  <= bage_in;
      nf_ff    <= nf_in;
      nr_ff    <= nr_in;
      st_ff    <= st_in;
      order_ff <= order_in;
      final_ff <= final_in;
      peff_ff  <= peff_in;
   end

   mts_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_due_ram (
      .clock(clock), .wr_en(due_we), .wr_addr(due_wa), .wr_data(due_wd),
      .rd_addr(rd_addr), .rd_data(due_q)
   );

   mts_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_period_ram (
      .clock(clock), .wr_en(per_we), .wr_addr(ix_slot), .wr_data(req_ff.period),
      .rd_addr(rd_addr), .rd_data(per_q)
   );

   mts_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_stamp_ram (
      .clock(clock), .wr_en(stm_we), .wr_addr(stm_wa), .wr_data(stm_wd),
      .rd_addr(rd_addr), .rd_data(stm_q)
   );

   mts_rem u_rem (
      .clock(clock), .reset(reset), .go(rem_go), .dividend(rem_dividend),
      .divisor(p_eff), .done(rem_done), .remainder(rem_q)
   );
endmodule

[rtl/core/mts_checker.sv]
// port level checks for the multi timer scheduler, bound to the top level
module mts_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input mts_pkg::rsp_type rsp_data
);
   // an accepted command keeps the block busy until its last result
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("command accepted but block not busy");

   a_more_results: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> busy)
      else $error("block idle before the last result of a transaction");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !busy)
      else $error("last result shown while still busy");

   a_fire_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fired |-> !rsp_data.last && rsp_data.wait_time == 32'd0)
      else $error("expiry result carries final fields");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");
endmodule

bind multi_timer_scheduler mts_checker u_mts_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);
